// ----- sv/bsf_pkg.sv -----
package bsf_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int DIM_BITS    = 16;
    localparam int SLOTS       = TABLE_DEPTH + 1;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int ID_W        = 32;
    localparam int FMT_W       = 4;
    localparam int TB_W        = 5;
    localparam int AREA_W      = 2 * DIM_BITS;
    localparam int SIZE_W      = AREA_W + 4;
    localparam int TOTAL_W     = SIZE_W + 5;
    localparam int ME_W        = 5;
    localparam int MB_W        = 37;
    localparam int QDEPTH      = 2;

    typedef enum logic [1:0] {
        OP_CAPTURE,
        OP_RESTORE,
        OP_RELEASE,
        OP_CONTAINS
    } op_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_ARGS,
        ST_UNSUPPORTED,
        ST_SELF_EVICTED,
        ST_NOT_FOUND,
        ST_EXTENT,
        ST_FORMAT
    } status_t;

    typedef enum logic [1:0] {
        K_CAPTURE,
        K_LOOKUP,
        K_REFUSE
    } kind_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_APPEND,
        B_EVICT,
        B_SCAN,
        B_DONE
    } bstate_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] h;
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] y;
        logic [DIM_BITS-1:0] x;
    } rect_t;

    typedef struct packed {
        kind_t               kind;
        op_t                 op;
        status_t             err;
        logic [ID_W-1:0]     id;
        rect_t               rect;
        logic [DIM_BITS-1:0] tw;
        logic [DIM_BITS-1:0] th;
        logic [FMT_W-1:0]    fmt;
        logic [AREA_W-1:0]   area;
    } job_t;

    typedef struct packed {
        status_t             status;
        logic [ID_W-1:0]     id;
        rect_t               rect;
        logic [TOTAL_W-1:0]  used;
        logic [CNT_W-1:0]    kept;
        logic [CNT_W-1:0]    evicted;
    } result_t;

    function automatic logic [TB_W-1:0] texel_bytes(input logic [FMT_W-1:0] fmt);
        logic [TB_W-1:0] tb;
        case (fmt)
            4'd0, 4'd1:                      tb = 5'd1;
            4'd2, 4'd3:                      tb = 5'd2;
            4'd4:                            tb = 5'd3;
            4'd5, 4'd6, 4'd7, 4'd8, 4'd9:    tb = 5'd4;
            4'd10, 4'd11:                    tb = 5'd8;
            4'd12:                           tb = 5'd16;
            default:                         tb = 5'd0;
        endcase
        return tb;
    endfunction

endpackage

// ----- sv/bsf_front.sv -----
module bsf_front
    import bsf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [135:0]        s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic                q_full,
    output logic                q_push,
    output job_t                q_data
);

    logic [ID_W-1:0]     id;
    logic [DIM_BITS-1:0] x, y, w, h, tw, th, wc, hc;
    logic [FMT_W-1:0]    fmt;
    logic                bad, unsup;
    logic                seen_reg;
    op_t                 op;

    assign op  = op_t'(s_tuser);
    assign id  = s_tdata[31:0];
    assign x   = s_tdata[47:32];
    assign y   = s_tdata[63:48];
    assign w   = s_tdata[79:64];
    assign h   = s_tdata[95:80];
    assign tw  = s_tdata[111:96];
    assign th  = s_tdata[127:112];
    assign fmt = s_tdata[131:128];

    assign s_tready = !q_full && seen_reg;
    assign q_push   = s_tvalid && s_tready;

    // hold off input until seen_reg has registered the release of reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= 1'b1;
        end
    end

    always_comb
    begin
        bad   = (w == '0) || (h == '0) || (x >= tw) || (y >= th);
        unsup = (texel_bytes(fmt) == '0);
        wc    = (w > tw - x) ? tw - x : w;
        hc    = (h > th - y) ? th - y : h;
        q_data.op   = op;
        q_data.id   = id;
        q_data.rect = '{h: hc, w: wc, y: y, x: x};
        q_data.tw   = tw;
        q_data.th   = th;
        q_data.fmt  = fmt;
        q_data.area = AREA_W'(wc) * AREA_W'(hc);
        q_data.err  = ST_OK;
        q_data.kind = K_LOOKUP;
        if (op == OP_CAPTURE)
        begin
            if (bad)
            begin
                q_data.kind = K_REFUSE;
                q_data.err  = ST_BAD_ARGS;
            end
            else if (unsup)
            begin
                q_data.kind = K_REFUSE;
                q_data.err  = ST_UNSUPPORTED;
            end
            else
            begin
                q_data.kind = K_CAPTURE;
            end
        end
        else if (id == '0)
        begin
            q_data.kind = K_REFUSE;
            q_data.err  = ST_BAD_ARGS;
        end
    end

endmodule

// ----- sv/bsf_queue.sv -----
module bsf_queue
    import bsf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    job_t             mem_reg [QDEPTH];
    logic             wr_reg, wr_next;
    logic             rd_reg, rd_next;
    logic [1:0]       cnt_reg, cnt_next;

    assign empty = (cnt_reg == 2'd0);
    assign full  = (cnt_reg == 2'(QDEPTH));
    assign head  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? !wr_reg : wr_reg;
        rd_next  = pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/bsf_back.sv -----
module bsf_back
    import bsf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [MB_W-1:0]   cfg_data,
    input  job_t              q_head,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output result_t           m_res
);

    bstate_t             state_reg, state_next;
    job_t                job_reg, job_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [ID_W-1:0]     nid_reg, nid_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    evict_reg, evict_next;
    status_t             status_reg, status_next;
    logic [ID_W-1:0]     rid_reg, rid_next;
    rect_t               rect_reg, rect_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;
    logic [ME_W-1:0]     max_entries_reg;
    logic [MB_W-1:0]     max_bytes_reg;

    logic [ID_W-1:0]     tab_id_reg   [SLOTS];
    rect_t               tab_rect_reg [SLOTS];
    logic [FMT_W-1:0]    tab_fmt_reg  [SLOTS];
    logic [SIZE_W-1:0]   tab_size_reg [SLOTS];

    logic                app_en, rm_en;
    logic [IDX_W-1:0]    rm_at;
    logic [SIZE_W-1:0]   new_size, rm_size;
    logic [CNT_W-1:0]    lim_e;
    logic [MB_W-1:0]     lim_b;
    rect_t               found;

    assign m_tvalid = out_valid_reg;
    assign m_res    = out_reg;
    assign new_size = SIZE_W'({4'b0, job_reg.area} * texel_bytes(job_reg.fmt));
    assign rm_size  = tab_size_reg[rm_at];
    assign found    = tab_rect_reg[idx_reg];

    always_comb
    begin
        if (max_entries_reg == '0)
        begin
            lim_e = CNT_W'(1);
        end
        else if (CNT_W'(max_entries_reg) > CNT_W'(TABLE_DEPTH))
        begin
            lim_e = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            lim_e = CNT_W'(max_entries_reg);
        end
        lim_b = (max_bytes_reg == '0) ? MB_W'(1) : max_bytes_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        nid_next       = nid_reg;
        idx_next       = idx_reg;
        evict_next     = evict_reg;
        status_next    = status_reg;
        rid_next       = rid_reg;
        rect_next      = rect_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        q_pop          = 1'b0;
        app_en         = 1'b0;
        rm_en          = 1'b0;
        rm_at          = '0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    job_next    = q_head;
                    idx_next    = '0;
                    evict_next  = '0;
                    rid_next    = '0;
                    rect_next   = '0;
                    status_next = ST_OK;
                    case (q_head.kind)
                        K_CAPTURE: state_next = B_APPEND;
                        K_LOOKUP:  state_next = B_SCAN;
                        default:
                        begin
                            status_next = q_head.err;
                            state_next  = B_DONE;
                        end
                    endcase
                end
            end
            B_APPEND:
            begin
                app_en     = 1'b1;
                total_next = total_reg + TOTAL_W'(new_size);
                count_next = count_reg + CNT_W'(1);
                rect_next  = job_reg.rect;
                rid_next   = nid_reg;
                nid_next   = (nid_reg + ID_W'(1) == '0) ? ID_W'(1) : nid_reg + ID_W'(1);
                state_next = B_EVICT;
            end
            B_EVICT:
            begin
                if (count_reg != '0 &&
                    (count_reg > lim_e || total_reg > TOTAL_W'(lim_b)))
                begin
                    rm_en      = 1'b1;
                    total_next = (total_reg < TOTAL_W'(rm_size)) ? '0 :
                                 total_reg - TOTAL_W'(rm_size);
                    count_next = count_reg - CNT_W'(1);
                    evict_next = evict_reg + CNT_W'(1);
                end
                else
                begin
                    if (count_reg == '0)
                    begin
                        status_next = ST_SELF_EVICTED;
                        rid_next    = '0;
                    end
                    state_next = B_DONE;
                end
            end
            B_SCAN:
            begin
                if (CNT_W'(idx_reg) >= count_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = B_DONE;
                end
                else if (tab_id_reg[idx_reg] == job_reg.id)
                begin
                    rect_next  = found;
                    state_next = B_DONE;
                    case (job_reg.op)
                        OP_RESTORE:
                        begin
                            if (({1'b0, found.x} + {1'b0, found.w} > {1'b0, job_reg.tw}) ||
                                ({1'b0, found.y} + {1'b0, found.h} > {1'b0, job_reg.th}))
                            begin
                                status_next = ST_EXTENT;
                            end
                            else if (tab_fmt_reg[idx_reg] != job_reg.fmt)
                            begin
                                status_next = ST_FORMAT;
                            end
                        end
                        OP_RELEASE:
                        begin
                            rm_en      = 1'b1;
                            rm_at      = idx_reg;
                            total_next = (total_reg < TOTAL_W'(rm_size)) ? '0 :
                                         total_reg - TOTAL_W'(rm_size);
                            count_next = count_reg - CNT_W'(1);
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            B_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next.status  = status_reg;
                    out_next.id      = rid_reg;
                    out_next.rect    = rect_reg;
                    out_next.used    = total_reg;
                    out_next.kept    = count_reg;
                    out_next.evicted = evict_reg;
                    out_valid_next   = 1'b1;
                    state_next       = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            count_reg       <= '0;
            total_reg       <= '0;
            nid_reg         <= ID_W'(1);
            out_valid_reg   <= 1'b0;
            max_entries_reg <= ME_W'(16);
            max_bytes_reg   <= MB_W'(268435456);
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            nid_reg       <= nid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && !cfg_index)
            begin
                max_entries_reg <= cfg_data[ME_W-1:0];
            end
            if (cfg_we && cfg_index)
            begin
                max_bytes_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        idx_reg    <= idx_next;
        evict_reg  <= evict_next;
        status_reg <= status_next;
        rid_reg    <= rid_next;
        rect_reg   <= rect_next;
        out_reg    <= out_next;
    end

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_slot
        always_ff @(posedge clk)
        begin
            if (rm_en && IDX_W'(k) >= rm_at)
            begin
                if (k < SLOTS - 1)
                begin
                    tab_id_reg[k]   <= tab_id_reg[(k + 1) % SLOTS];
                    tab_rect_reg[k] <= tab_rect_reg[(k + 1) % SLOTS];
                    tab_fmt_reg[k]  <= tab_fmt_reg[(k + 1) % SLOTS];
                    tab_size_reg[k] <= tab_size_reg[(k + 1) % SLOTS];
                end
            end
            else if (app_en && IDX_W'(k) == IDX_W'(count_reg))
            begin
                tab_id_reg[k]   <= nid_reg;
                tab_rect_reg[k] <= job_reg.rect;
                tab_fmt_reg[k]  <= job_reg.fmt;
                tab_size_reg[k] <= new_size;
            end
        end
    end

endmodule

// ----- sv/budgeted_snapshot_fifo_unit.sv -----
// Snapshot record table kept oldest first under an entry budget and a byte
// budget. Each transaction on the slave side is classified up front (rectangle
// check and clamp, format lookup, id check) and queued in a two-entry queue; a
// back-end sequencer then works the record table one slot per cycle. A refused
// transaction goes straight to its result, a capture appends its record and
// then evicts the oldest records one by one while a budget is exceeded, and a
// restore, release or contains scans from the oldest record to the match or the
// end of the table. Results wait in an output register; while a result is
// stalled, up to three more transactions are still taken, two of them queued.
// Write configuration only while no transaction is in flight.
module budgeted_snapshot_fifo_unit
    import bsf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [36:0]   cfg_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    // snap_id, rect_x, rect_y, rect_w, rect_h, tex_width, tex_height, pixel_format
    input  logic [135:0]  s_tdata,
    // op
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // result_id, out_x, out_y, out_w, out_h, used_bytes, kept_count, evicted_now
    output logic [151:0]  m_tdata,
    // status
    output logic [2:0]    m_tuser
);

    job_t    q_in, q_head;
    logic    q_push, q_pop, q_empty, q_full;
    result_t res;

    bsf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    bsf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    bsf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (res)
    );

    assign m_tuser = res.status;
    assign m_tdata = {5'b0, res.evicted, res.kept, res.used,
                      res.rect.h, res.rect.w, res.rect.y, res.rect.x, res.id};

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import bsf_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        status_t     status;
        logic [31:0] id;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
        logic [40:0] used;
        logic [4:0]  kept;
        logic [4:0]  evicted;
    } snap_result_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic         cfg_index;
    logic [36:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;
    logic [2:0]   m_tuser;

    logic [31:0] tbl_id [SLOTS];
    logic [63:0] tbl_rect [SLOTS];
    logic [3:0]  tbl_fmt [SLOTS];
    logic [35:0] tbl_size [SLOTS];
    int unsigned tbl_count;
    logic [40:0] tbl_total;
    logic [31:0] next_id;
    logic [4:0]  lim_entries;
    logic [36:0] lim_bytes;

    snap_result_t pending_results[$];
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_rx;
    int unsigned mismatches;
    int unsigned cycles;

    budgeted_snapshot_fifo_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [4:0] texel_size(input logic [3:0] fmt);
        case (fmt)
            4'd0, 4'd1:                   return 5'd1;
            4'd2, 4'd3:                   return 5'd2;
            4'd4:                         return 5'd3;
            4'd5, 4'd6, 4'd7, 4'd8, 4'd9: return 5'd4;
            4'd10, 4'd11:                 return 5'd8;
            4'd12:                        return 5'd16;
            default:                      return 5'd0;
        endcase
    endfunction

    task automatic drop_record(input int unsigned i);
        if (i < tbl_count)
        begin
            tbl_total -= (tbl_total < tbl_size[i]) ? tbl_total : 41'(tbl_size[i]);
            for (int unsigned k = i; k + 1 < tbl_count; k++)
            begin
                tbl_id[k]   = tbl_id[k + 1];
                tbl_rect[k] = tbl_rect[k + 1];
                tbl_fmt[k]  = tbl_fmt[k + 1];
                tbl_size[k] = tbl_size[k + 1];
            end
            tbl_count--;
        end
    endtask

    task automatic predict_snapshot(input op_t op, input logic [135:0] d);
        snap_result_t r;
        logic [31:0] id;
        logic [16:0] x, y, w, h, tw, th;
        logic [3:0]  fmt;
        logic [63:0] rect;
        int unsigned le;
        logic [37:0] lb;
        int          found;
        id = d[31:0];
        x = d[47:32];
        y = d[63:48];
        w = d[79:64];
        h = d[95:80];
        tw = d[111:96];
        th = d[127:112];
        fmt = d[131:128];
        rect = '0;
        found = -1;
        r.status = ST_OK;
        r.id = '0;
        r.evicted = '0;
        if (op == OP_CAPTURE)
        begin
            if (w == 0 || h == 0 || x >= tw || y >= th)
                r.status = ST_BAD_ARGS;
            else if (texel_size(fmt) == 0)
                r.status = ST_UNSUPPORTED;
            else
            begin
                le = (lim_entries == 0) ? 1 : lim_entries;
                if (le > TABLE_DEPTH)
                    le = TABLE_DEPTH;
                lb = (lim_bytes == 0) ? 1 : lim_bytes;
                if (w > tw - x)
                    w = tw - x;
                if (h > th - y)
                    h = th - y;
                rect = {h[15:0], w[15:0], y[15:0], x[15:0]};
                r.id = next_id;
                next_id = next_id + 1;
                if (next_id == 0)
                    next_id = 1;
                if (tbl_count >= SLOTS)
                begin
                    drop_record(0);
                    r.evicted++;
                end
                tbl_id[tbl_count] = r.id;
                tbl_rect[tbl_count] = rect;
                tbl_fmt[tbl_count] = fmt;
                tbl_size[tbl_count] = 36'(w) * 36'(h) * 36'(texel_size(fmt));
                tbl_total += tbl_size[tbl_count];
                tbl_count++;
                while (tbl_count > 0 && (tbl_count > le || tbl_total > lb))
                begin
                    drop_record(0);
                    r.evicted++;
                end
                if (tbl_count == 0)
                begin
                    r.status = ST_SELF_EVICTED;
                    r.id = '0;
                end
            end
        end
        else if (id == 0)
            r.status = ST_BAD_ARGS;
        else
        begin
            for (int unsigned i = 0; i < tbl_count && found < 0; i++)
                if (tbl_id[i] == id)
                    found = i;
            if (found < 0)
                r.status = ST_NOT_FOUND;
            else
            begin
                rect = tbl_rect[found];
                if (op == OP_RESTORE)
                begin
                    if (17'(rect[15:0]) + 17'(rect[47:32]) > tw ||
                        17'(rect[31:16]) + 17'(rect[63:48]) > th)
                        r.status = ST_EXTENT;
                    else if (tbl_fmt[found] != fmt)
                        r.status = ST_FORMAT;
                end
                else if (op == OP_RELEASE)
                    drop_record(found);
            end
        end
        r.x = rect[15:0];
        r.y = rect[31:16];
        r.w = rect[47:32];
        r.h = rect[63:48];
        r.used = tbl_total;
        r.kept = 5'(tbl_count);
        pending_results = {pending_results, r};
    endtask

    task automatic send_snapshot(input op_t op, input logic [31:0] id,
                                 input logic [15:0] x, input logic [15:0] y,
                                 input logic [15:0] w, input logic [15:0] h,
                                 input logic [15:0] tw, input logic [15:0] th,
                                 input logic [3:0] fmt);
        logic [135:0] d;
        d = {4'd0, fmt, th, tw, h, w, y, x, id};
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = d;
        s_tuser = op;
        do
            @(posedge clk);
        while (!s_tready);
        predict_snapshot(op, d);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(input bit idx, input logic [36:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == 1'b0)
            lim_entries = val[4:0];
        else
            lim_bytes = val;
    endtask

    task automatic send_random_item();
        int unsigned sel;
        int unsigned pick;
        logic [31:0] id;
        logic [15:0] x, y, w, h, tw, th;
        logic [3:0]  fmt;
        sel = $urandom_range(99);
        id = $urandom;
        fmt = ($urandom_range(9) == 0) ? 4'($urandom_range(13, 15)) : 4'($urandom_range(12));
        if ($urandom_range(9) == 0)
        begin
            x = $urandom; y = $urandom; w = $urandom; h = $urandom;
            tw = $urandom; th = $urandom;
        end
        else
        begin
            tw = $urandom_range(64); th = $urandom_range(64);
            x = $urandom_range(70); y = $urandom_range(70);
            w = $urandom_range(70); h = $urandom_range(70);
        end
        if (sel < 45)
            send_snapshot(OP_CAPTURE, id, x, y, w, h, tw, th, fmt);
        else
        begin
            if (tbl_count > 0 && $urandom_range(9) < 7)
            begin
                pick = $urandom_range(tbl_count - 1);
                id = tbl_id[pick];
                if ($urandom_range(3) != 0)
                begin
                    tw = tbl_rect[pick][15:0] + tbl_rect[pick][47:32] + $urandom_range(1);
                    th = tbl_rect[pick][31:16] + tbl_rect[pick][63:48] + $urandom_range(1);
                    if ($urandom_range(7) == 0)
                        tw = tw - 1;
                    if ($urandom_range(3) != 0)
                        fmt = tbl_fmt[pick];
                end
            end
            else if ($urandom_range(4) == 0)
                id = '0;
            else if ($urandom_range(1) == 0)
                id = next_id - $urandom_range(1, 30);
            send_snapshot(op_t'(sel < 70 ? OP_RESTORE : sel < 85 ? OP_RELEASE : OP_CONTAINS),
                          id, x, y, w, h, tw, th, fmt);
        end
    endtask

    task automatic test_directed();
        send_snapshot(OP_CAPTURE, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd0);
        send_snapshot(OP_CAPTURE, 0, 16'hFFFE, 16'hFFFE, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 16'hFFFF, 4'd12);
        send_snapshot(OP_CAPTURE, 0, 1, 2, 0, 5, 10, 10, 4'd5);
        send_snapshot(OP_CAPTURE, 0, 1, 2, 5, 0, 10, 10, 4'd5);
        send_snapshot(OP_CAPTURE, 0, 10, 2, 5, 5, 10, 10, 4'd5);
        send_snapshot(OP_CAPTURE, 0, 0, 0, 5, 5, 0, 0, 4'd5);
        send_snapshot(OP_CAPTURE, 0, 1, 1, 4, 4, 8, 8, 4'd13);
        send_snapshot(OP_CAPTURE, 0, 1, 1, 4, 4, 8, 8, 4'd15);
        send_snapshot(OP_CAPTURE, 0, 3, 4, 20, 20, 16, 16, 4'd4);
        send_snapshot(OP_CAPTURE, 0, 0, 0, 8, 8, 8, 8, 4'd10);
        send_snapshot(OP_RESTORE, next_id - 2, 0, 0, 0, 0, 16, 16, 4'd4);
        send_snapshot(OP_RESTORE, next_id - 2, 0, 0, 0, 0, 15, 16, 4'd4);
        send_snapshot(OP_RESTORE, next_id - 2, 0, 0, 0, 0, 16, 16, 4'd3);
        send_snapshot(OP_RESTORE, 0, 0, 0, 0, 0, 16, 16, 4'd4);
        send_snapshot(OP_RELEASE, 0, 0, 0, 0, 0, 0, 0, 4'd0);
        send_snapshot(OP_CONTAINS, 0, 0, 0, 0, 0, 0, 0, 4'd0);
        send_snapshot(OP_CONTAINS, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 4'd0);
        send_snapshot(OP_CONTAINS, next_id - 1, 0, 0, 0, 0, 0, 0, 4'd0);
        send_snapshot(OP_RELEASE, next_id - 2, 0, 0, 0, 0, 0, 0, 4'd0);
        send_snapshot(OP_RELEASE, next_id - 2, 0, 0, 0, 0, 0, 0, 4'd0);
        wait_drained();
        write_reg(1'b1, 37'd100);
        write_reg(1'b0, 5'd0);
        send_snapshot(OP_CAPTURE, 0, 0, 0, 20, 20, 20, 20, 4'd0);
        send_snapshot(OP_CAPTURE, 0, 0, 0, 5, 5, 20, 20, 4'd0);
        wait_drained();
        write_reg(1'b1, 37'd0);
        send_snapshot(OP_CAPTURE, 0, 0, 0, 1, 1, 1, 1, 4'd0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        write_reg(1'b0, 5'd16);
        write_reg(1'b1, 37'd268435456);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                hold_rx = 1'b1;
                repeat (400) @(negedge clk);
                hold_rx = 1'b0;
            end
            repeat (30) send_random_item();
        join
        wait_drained();
    endtask

    task automatic test_random();
        logic [36:0] byte_lims [6];
        logic [4:0]  entry_lims [6];
        entry_lims = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd9};
        byte_lims = '{37'd268435456, 37'h1F_FFFF_FFFF, 37'd5000, 37'd0, 37'd1,
                      37'd20000};
        for (int p = 0; p < 6; p++)
        begin
            send_idle_pct = (p < 2) ? 6 : (p < 4) ? 65 : 0;
            recv_idle_pct = (p < 2) ? 65 : (p < 4) ? 6 : 0;
            write_reg(1'b0, entry_lims[p]);
            write_reg(1'b1, byte_lims[p]);
            repeat (310) send_random_item();
            wait_drained();
        end
    endtask

    always @(negedge clk)
        m_tready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        snap_result_t e;
        snap_result_t a;
        if (rst_n && m_tvalid && m_tready)
        begin
            a.status = status_t'(m_tuser);
            a.id = m_tdata[31:0];
            a.x = m_tdata[47:32];
            a.y = m_tdata[63:48];
            a.w = m_tdata[79:64];
            a.h = m_tdata[95:80];
            a.used = m_tdata[136:96];
            a.kept = m_tdata[141:137];
            a.evicted = m_tdata[146:142];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %p", a);
            end
            else
            begin
                e = pending_results.pop_front();
                if (a != e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch:\n  expected %p\n  actual   %p", e, a);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** budgeted_snapshot_fifo_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        hold_rx = 1'b0;
        send_idle_pct = 6;
        recv_idle_pct = 65;
        mismatches = 0;
        cycles = 0;
        tbl_count = 0;
        tbl_total = '0;
        next_id = 1;
        lim_entries = 5'd16;
        lim_bytes = 37'd268435456;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_backpressure();
        test_random();
        if (pending_results.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("** budgeted_snapshot_fifo_unit: PASSED **");
        else
            $display("** budgeted_snapshot_fifo_unit: FAILED **");
        $finish;
    end

endmodule
